// ----- design/klk_pkg.sv -----
`default_nettype none

package klk_pkg;

    // Number of code digits held and compared
    localparam int unsigned CODE_DIGITS_DEF = 4;

    localparam int unsigned CFG_INDEX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_WORD     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_TICKS   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRANT_TICKS   = 2'd3;

    // Register values after reset; the code word reads "1772" in ASCII
    localparam logic [31:0] CODE_WORD_RST     = 32'd825702194;
    localparam logic [15:0] BLINK_TICKS_RST   = 16'd200;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;
    localparam logic [15:0] GRANT_TICKS_RST   = 16'd3000;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ENTRY   = 2'd1,
        MODE_GRANTED = 2'd2
    } klk_mode_t;

    typedef struct packed {
        logic        start_pressed;
        logic        key_valid;
        logic [7:0]  key_char;
    } klk_item_t;

    typedef struct packed {
        logic [31:0] code_word;
        logic [15:0] blink_ticks;
        logic [15:0] timeout_ticks;
        logic [15:0] grant_ticks;
    } klk_cfg_t;

endpackage

`default_nettype wire

// ----- design/klk_cfg_regs.sv -----
`default_nettype none

module klk_cfg_regs
    import klk_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    output klk_cfg_t                    cfg
);

    klk_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_word     <= CODE_WORD_RST;
            cfg_reg.blink_ticks   <= BLINK_TICKS_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
            cfg_reg.grant_ticks   <= GRANT_TICKS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CODE_WORD:     cfg_reg.code_word     <= cfg_data;
                CFG_BLINK_TICKS:   cfg_reg.blink_ticks   <= cfg_data[15:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[15:0];
                CFG_GRANT_TICKS:   cfg_reg.grant_ticks   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/klk_in_reg.sv -----
`default_nettype none

module klk_in_reg
    import klk_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire klk_item_t s_item,
    output logic           item_valid,
    input  wire logic      item_ready,
    output klk_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    klk_item_t item_reg;

    // The register frees up in the same cycle that the core takes its item.
    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/klk_core.sv -----
`default_nettype none

module klk_core
    import klk_pkg::*;
#(
    parameter int unsigned CODE_DIGITS = CODE_DIGITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire klk_cfg_t  cfg,
    input  wire logic      item_valid,
    output logic           item_ready,
    input  wire klk_item_t item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output logic           m_red_led,
    output logic           m_green_led,
    output logic [1:0]     m_lock_mode
);

    localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);

    klk_mode_t         mode_reg, mode_next;
    logic [7:0]        store_reg  [CODE_DIGITS];
    logic [7:0]        store_next [CODE_DIGITS];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [15:0]       blink_reg, blink_next, blink_base;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic [15:0]       hold_reg, hold_next;
    logic              red_reg, red_next;
    logic              green;
    logic              match;
    logic              advance;

    logic              out_valid_reg;
    logic              out_red_reg;
    logic              out_green_reg;
    klk_mode_t         out_mode_reg;

    // Expected character for a slot, counted in bytes down from the first digit.
    function automatic logic [7:0] exp_byte(input logic [31:0] code, input int unsigned b);
        if (b > 3) begin
            return 8'd0;
        end
        return code[8*b +: 8];
    endfunction

    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    assign item_ready  = !out_valid_reg || m_ready;
    assign advance     = item_valid && item_ready;
    assign m_valid     = out_valid_reg;
    assign m_red_led   = out_red_reg;
    assign m_green_led = out_green_reg;
    assign m_lock_mode = out_mode_reg;

    always_comb begin
        mode_next    = mode_reg;
        store_next   = store_reg;
        count_next   = count_reg;
        blink_next   = blink_reg;
        blink_base   = blink_reg;
        elapsed_next = elapsed_reg;
        hold_next    = hold_reg;
        red_next     = red_reg;
        green        = 1'b0;
        match        = 1'b1;
        case (mode_reg)
            MODE_ENTRY: begin
                if (blink_reg >= cfg.blink_ticks) begin
                    red_next   = !red_reg;
                    blink_base = 16'd0;
                end
                blink_next   = bump16(blink_base);
                elapsed_next = bump16(elapsed_reg);
                if (elapsed_next >= cfg.timeout_ticks) begin
                    // A timeout drops any key arriving in the same tick.
                    mode_next = MODE_IDLE;
                end else begin
                    if (item.key_valid) begin
                        green = 1'b1;
                        if (count_reg < CNT_W'(CODE_DIGITS)) begin
                            for (int i = 0; i < CODE_DIGITS; i++) begin
                                if (count_reg == CNT_W'(i)) begin
                                    store_next[i] = item.key_char;
                                end
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    if (count_next >= CNT_W'(CODE_DIGITS)) begin
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                            if (store_next[i] !=
                                exp_byte(cfg.code_word, CODE_DIGITS - 1 - i)) begin
                                match = 1'b0;
                            end
                        end
                        if (match) begin
                            mode_next = MODE_GRANTED;
                            hold_next = 16'd0;
                        end else begin
                            mode_next = MODE_IDLE;
                        end
                    end
                end
            end
            MODE_GRANTED: begin
                red_next  = 1'b0;
                green     = 1'b1;
                hold_next = bump16(hold_reg);
                if (hold_next >= cfg.grant_ticks) begin
                    mode_next = MODE_IDLE;
                    hold_next = 16'd0;
                end
            end
            default: begin
                // The unused mode code behaves as idle.
                mode_next  = MODE_IDLE;
                red_next   = 1'b1;
                count_next = '0;
                for (int i = 0; i < CODE_DIGITS; i++) begin
                    store_next[i] = 8'd0;
                end
                if (item.start_pressed) begin
                    mode_next    = MODE_ENTRY;
                    blink_next   = 16'd0;
                    elapsed_next = 16'd0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            blink_reg   <= 16'd0;
            elapsed_reg <= 16'd0;
            hold_reg    <= 16'd0;
            red_reg     <= 1'b1;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                store_reg[i] <= 8'd0;
            end
        end else if (advance) begin
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            blink_reg   <= blink_next;
            elapsed_reg <= elapsed_next;
            hold_reg    <= hold_next;
            red_reg     <= red_next;
            store_reg   <= store_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_red_reg   <= red_next;
            out_green_reg <= green;
            out_mode_reg  <= mode_next;
        end
    end

    // Entry is left as soon as the last digit is in, so it never holds a full buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_ENTRY) |-> (count_reg < CNT_W'(CODE_DIGITS)))
        else $error("digit count full while still in entry");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode_reg == MODE_GRANTED)
        |=> (out_valid_reg && out_green_reg && !out_red_reg))
        else $error("granted tick did not show green on and red off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode_reg != MODE_ENTRY && mode_reg != MODE_GRANTED)
        |=> (count_reg == '0 && red_reg))
        else $error("idle tick did not clear the digit count and set red");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && mode_reg != MODE_ENTRY && mode_reg != MODE_GRANTED
         && !item.start_pressed) |=> (mode_reg == MODE_IDLE && !out_green_reg))
        else $error("left idle without a start press");

endmodule

`default_nettype wire

// ----- design/keypad_code_lock_fsm.sv -----
// Keypad code lock controller.
// Each transaction on the s_ channel is one millisecond tick carrying the start
// button level and an optional debounced key. Every tick yields exactly one
// transaction on the m_ channel with the red and green LED levels and the lock
// mode after that tick (0 idle, 1 entering, 2 granted).
// An input transaction is taken into an input register, worked on by the core
// cycle and written to an output register. One tick is accepted every cycle while
// the m_ side takes results; the rate is set by the single pass from input
// register to output register.
// When the m_ side stalls, the output register holds its result and the input
// register takes one further tick, after which s_ready stays low until the
// result is taken.
// The cfg_ channel writes the code word (index 0), blink, timeout and grant
// tick counts (indexes 1 to 3); cfg_ready is always high. The user must make
// writes while no tick is in flight; the block itself does not enforce this.
// After reset the lock is idle with red on, the counters at zero, an empty
// digit buffer and the configuration at its default values.
`default_nettype none

module keypad_code_lock_fsm
    import klk_pkg::*;
#(
    parameter int unsigned CODE_DIGITS = CODE_DIGITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_start_pressed,
    input  wire logic                   s_key_valid,
    input  wire logic [7:0]             s_key_char,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_red_led,
    output logic                        m_green_led,
    output logic [1:0]                  m_lock_mode,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data
);

    klk_cfg_t  cfg;
    klk_item_t s_item;
    klk_item_t item;
    logic      item_valid;
    logic      item_ready;

    always_comb begin
        s_item.start_pressed = s_start_pressed;
        s_item.key_valid     = s_key_valid;
        s_item.key_char      = s_key_char;
    end

    klk_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    klk_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    klk_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_led   (m_red_led),
        .m_green_led (m_green_led),
        .m_lock_mode (m_lock_mode)
    );

endmodule

`default_nettype wire

// ----- tb/sv/keypad_code_lock_fsm_test.sv -----
module keypad_code_lock_fsm_test;
    timeunit 1ns;
    timeprecision 1ps;

    import klk_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    class lock_scoreboard;
        typedef struct packed {
            logic       red;
            logic       green;
            logic [1:0] mode;
        } lamps_t;

        logic [31:0] code_word;
        logic [15:0] blink_ticks;
        logic [15:0] timeout_ticks;
        logic [15:0] grant_ticks;
        klk_mode_t   mode;
        logic [7:0]  digits[CODE_DIGITS_DEF];
        int unsigned n_digits;
        int unsigned blink_cnt;
        int unsigned elapsed_cnt;
        int unsigned hold_cnt;
        logic        red;
        lamps_t      lamps_due[$];
        int unsigned errors;

        function new();
            code_word     = CODE_WORD_RST;
            blink_ticks   = BLINK_TICKS_RST;
            timeout_ticks = TIMEOUT_TICKS_RST;
            grant_ticks   = GRANT_TICKS_RST;
            mode          = MODE_IDLE;
            n_digits      = 0;
            blink_cnt     = 0;
            elapsed_cnt   = 0;
            hold_cnt      = 0;
            red           = 1'b1;
            errors        = 0;
            foreach (digits[i]) digits[i] = 8'h00;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_CODE_WORD:     code_word = data;
                CFG_BLINK_TICKS:   blink_ticks = data[15:0];
                CFG_TIMEOUT_TICKS: timeout_ticks = data[15:0];
                CFG_GRANT_TICKS:   grant_ticks = data[15:0];
                default: ;
            endcase
        endfunction

        function int unsigned bump(int unsigned v);
            return (v >= 65535) ? 65535 : v + 1;
        endfunction

        // The first digit sits in the highest used byte of the code word;
        // positions beyond byte 3 expect a zero byte.
        function bit code_ok();
            int b;
            for (int i = 0; i < CODE_DIGITS_DEF; i++) begin
                b = CODE_DIGITS_DEF - 1 - i;
                if (b > 3) begin
                    if (digits[i] != 8'h00) return 1'b0;
                end else if (digits[i] != code_word[8*b +: 8]) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_tick(klk_item_t item);
            lamps_t due;
            logic   green;
            green = 1'b0;
            case (mode)
                MODE_ENTRY: begin
                    if (blink_cnt >= blink_ticks) begin
                        red = ~red;
                        blink_cnt = 0;
                    end
                    blink_cnt = bump(blink_cnt);
                    elapsed_cnt = bump(elapsed_cnt);
                    // A timeout wins over a key arriving in the same tick.
                    if (elapsed_cnt >= timeout_ticks) begin
                        mode = MODE_IDLE;
                    end else begin
                        if (item.key_valid) begin
                            green = 1'b1;
                            if (n_digits < CODE_DIGITS_DEF) begin
                                digits[n_digits] = item.key_char;
                                n_digits++;
                            end
                        end
                        if (n_digits >= CODE_DIGITS_DEF) begin
                            if (code_ok()) begin
                                mode = MODE_GRANTED;
                                hold_cnt = 0;
                            end else begin
                                mode = MODE_IDLE;
                            end
                        end
                    end
                end
                MODE_GRANTED: begin
                    red = 1'b0;
                    green = 1'b1;
                    hold_cnt = bump(hold_cnt);
                    if (hold_cnt >= grant_ticks) begin
                        mode = MODE_IDLE;
                        hold_cnt = 0;
                    end
                end
                default: begin
                    mode = MODE_IDLE;
                    red = 1'b1;
                    n_digits = 0;
                    foreach (digits[i]) digits[i] = 8'h00;
                    if (item.start_pressed) begin
                        mode = MODE_ENTRY;
                        blink_cnt = 0;
                        elapsed_cnt = 0;
                    end
                end
            endcase
            due.red = red;
            due.green = green;
            due.mode = mode;
            lamps_due.push_back(due);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void check_result(logic red_a, logic green_a, logic [1:0] mode_a);
            lamps_t due;
            if (lamps_due.size() == 0) begin
                flag($sformatf("unexpected tick result: red %0b green %0b mode %0d",
                               red_a, green_a, mode_a));
                return;
            end
            due = lamps_due.pop_front();
            if (due.red !== red_a || due.green !== green_a || due.mode !== mode_a) begin
                flag($sformatf({"tick result mismatch: expected red %0b green %0b mode %0d,",
                                " got red %0b green %0b mode %0d"},
                               due.red, due.green, due.mode, red_a, green_a, mode_a));
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_start_pressed;
    logic                   s_key_valid;
    logic [7:0]             s_key_char;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_red_led;
    logic                   m_green_led;
    logic [1:0]             m_lock_mode;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    lock_scoreboard sb = new();
    bit             idling_on = 1'b1;
    int             ticks_sent = 0;
    int             cycle_count = 0;
    logic [31:0]    cur_code = CODE_WORD_RST;

    keypad_code_lock_fsm i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_start_pressed (s_start_pressed),
        .s_key_valid     (s_key_valid),
        .s_key_char      (s_key_char),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_led       (m_red_led),
        .m_green_led     (m_green_led),
        .m_lock_mode     (m_lock_mode),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idling_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: take every result, with random back-pressure after a transaction.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_red_led, m_green_led, m_lock_mode);
            if (!idling_on) stall_left = 0;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready) stall_left = pick_gap();
            end
        end
    end

    task automatic send_tick(input logic st, input logic kv, input logic [7:0] kc);
        klk_item_t item;
        int        gap;
        item.start_pressed = st;
        item.key_valid = kv;
        item.key_char = kc;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_pressed <= st;
        s_key_valid <= kv;
        s_key_char <= kc;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(item);
        ticks_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.lamps_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Keeps ticking until the lock is back in idle; fast runs switch idling off.
    task automatic run_out(input bit keys_on, input bit fast);
        bit saved;
        saved = idling_on;
        if (fast) idling_on = 1'b0;
        while (sb.mode != MODE_IDLE)
            send_tick(coin(), keys_on ? coin() : 1'b0, any_byte());
        idling_on = saved;
    endtask

    task automatic load_config(input logic [31:0] code, input logic [15:0] blink,
                               input logic [15:0] timeout, input logic [15:0] grant);
        logic [CFG_INDEX_W-1:0] idx[4];
        logic [31:0]            val[4];
        logic [31:0]            noise;
        idx = '{CFG_CODE_WORD, CFG_BLINK_TICKS, CFG_TIMEOUT_TICKS, CFG_GRANT_TICKS};
        noise = $urandom;
        // Upper bits of the 16-bit registers carry junk that must be dropped.
        val = '{code, {noise[31:16], blink}, {noise[15:0], timeout}, {~noise[31:16], grant}};
        drain();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        cur_code = code;
    endtask

    task automatic random_config();
        logic [31:0] code;
        logic [15:0] blink;
        logic [15:0] timeout;
        logic [15:0] grant;
        if (coin()) begin
            for (int i = 0; i < 4; i++) code[8*i +: 8] = 8'h30 + 8'($urandom_range(0, 9));
        end else begin
            code = $urandom;
        end
        blink = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
        timeout = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 6))
                                              : 16'($urandom_range(10, 60));
        grant = 16'($urandom_range(1, 40));
        load_config(code, blink, timeout, grant);
        idling_on = ($urandom_range(0, 3) != 0);
    endtask

    // One go at the keypad: start, four keys with filler ticks between them,
    // mostly the right digits. Now and then only line noise instead.
    task automatic code_attempt();
        logic [7:0] ch;
        int         b;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 5)) send_tick(coin(), coin(), any_byte());
        end else begin
            repeat ($urandom_range(0, 2)) send_tick(1'b0, coin(), any_byte());
            send_tick(1'b1, coin(), any_byte());
            for (int i = 0; i < CODE_DIGITS_DEF; i++) begin
                repeat ($urandom_range(0, 3)) send_tick(coin(), 1'b0, any_byte());
                b = CODE_DIGITS_DEF - 1 - i;
                ch = ($urandom_range(0, 9) != 0) ? cur_code[8*b +: 8] : any_byte();
                send_tick(coin(), 1'b1, ch);
            end
        end
        run_out(1'b1, 1'b0);
    endtask

    initial begin
        int phase_start;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_start_pressed <= 1'b0;
        s_key_valid <= 1'b0;
        s_key_char <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CODE_WORD;
        cfg_data <= 32'h0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Default code "1772": a key in idle is ignored, start and keys pressed
        // together in entry, then a granted hold cut short by a smaller grant count.
        send_tick(1'b0, 1'b1, "1");
        send_tick(1'b1, 1'b0, 8'h00);
        send_tick(1'b0, 1'b1, "1");
        send_tick(1'b1, 1'b1, "7");
        send_tick(1'b0, 1'b0, 8'hFF);
        send_tick(1'b0, 1'b1, "7");
        send_tick(1'b0, 1'b1, "2");
        repeat (6) send_tick(coin(), coin(), any_byte());
        load_config(CODE_WORD_RST, 16'd6, 16'd40, 16'd5);
        run_out(1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 8'h00);
        // Wrong code including the zero and all-ones characters.
        send_tick(1'b1, 1'b0, 8'h00);
        send_tick(1'b0, 1'b1, 8'h00);
        send_tick(1'b0, 1'b1, 8'hFF);
        send_tick(1'b0, 1'b1, "7");
        send_tick(1'b0, 1'b1, "2");
        // Entry left alone until it times out, red blinking all the while.
        send_tick(1'b1, 1'b0, 8'h00);
        run_out(1'b0, 1'b1);

        // Zero blink and grant counts; zero characters match a zero code.
        load_config(32'h0000_0000, 16'd0, 16'd8, 16'd0);
        send_tick(1'b1, 1'b0, 8'h00);
        repeat (4) send_tick(1'b0, 1'b1, 8'h00);
        run_out(1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 8'h00);

        // Zero timeout: entry ends on its first tick and that key is dropped.
        load_config(32'hA5C3_0F96, 16'd1, 16'd0, 16'd1);
        send_tick(1'b1, 1'b0, 8'h00);
        send_tick(1'b0, 1'b1, 8'hA5);
        send_tick(1'b0, 1'b0, 8'h00);

        // Largest settings; the hold and then the entry are cut
        // short by writing smaller counts while the lock is in that mode.
        load_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(1'b1, 1'b0, 8'h00);
        repeat (4) send_tick(coin(), 1'b1, 8'hFF);
        repeat (10) send_tick(coin(), coin(), any_byte());
        load_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd2);
        run_out(1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 8'h00);
        repeat (10) send_tick(1'b0, 1'b0, 8'h00);
        load_config(32'hFFFF_FFFF, 16'hFFFF, 16'd4, 16'd2);
        run_out(1'b0, 1'b1);

        repeat (6) begin
            random_config();
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < 85) begin
                code_attempt();
                // Occasionally hold back until every outstanding result is in.
                if ($urandom_range(0, 19) == 0) drain();
            end
        end
        idling_on = 1'b1;

        drain();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- keypad_code_lock_fsm.f -----
design/klk_pkg.sv
design/klk_cfg_regs.sv
design/klk_in_reg.sv
design/klk_core.sv
design/keypad_code_lock_fsm.sv
tb/sv/keypad_code_lock_fsm_test.sv
